// ===== hdl/oba_pkg.sv =====
// Shared types and constants of the OHLC bar aggregator.
`default_nettype none

package oba_pkg;

    localparam int TS_W       = 32;
    localparam int PRICE_W    = 32;
    localparam int VOL_IN_W   = 32;
    localparam int VOL_W      = 42;
    localparam int CNT_W      = 11;
    localparam int SKIP_W     = 16;
    localparam int PERIOD_W   = 6;
    localparam int MIN_W      = 6;
    localparam int Q60_W      = 27;
    localparam int MUL_W      = 64;
    localparam int DIV_SHIFT  = 37;
    localparam int IN_DATA_W  = 192;
    localparam int OUT_DATA_W = 216;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // floor(x / 60) == (x * DIV60_MAGIC) >> DIV_SHIFT for any 32-bit x
    localparam logic [31:0]      DIV60_MAGIC = 32'h8888_8889;
    localparam logic [CNT_W-1:0] MAX_RATIO   = 11'd1024;

    localparam logic [CFG_IDX_W-1:0] REG_RATIO  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SKIP   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 2'd2;

    typedef struct packed {
        logic [TS_W-1:0]     ts;
        logic [PRICE_W-1:0]  open;
        logic [PRICE_W-1:0]  high;
        logic [PRICE_W-1:0]  low;
        logic [PRICE_W-1:0]  close;
        logic [VOL_IN_W-1:0] volume;
    } bar_t;

    typedef struct packed {
        logic [TS_W-1:0]    ts;
        logic [PRICE_W-1:0] open;
        logic [PRICE_W-1:0] high;
        logic [PRICE_W-1:0] low;
        logic [PRICE_W-1:0] close;
        logic [VOL_W-1:0]   volume;
        logic [CNT_W-1:0]   count;
        logic               last;
    } out_bar_t;

    typedef struct packed {
        logic capture;
        logic mul_ts;
        logic mul_q60;
        logic minute_load;
        logic mod_step;
        logic accumulate;
        logic load_out;
        logic out_last;
        logic clear_group;
    } oba_cmd_t;

    typedef struct packed {
        logic rem_zero;
        logic group_full;
        logic out_free;
    } oba_stat_t;

endpackage

`default_nettype wire

// ===== hdl/oba_datapath.sv =====
// Datapath: input capture, minute-of-hour arithmetic, group accumulators, output register.
`default_nettype none

module oba_datapath
    import oba_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire bar_t                bar_in,
    input  wire oba_cmd_t            cmd,
    input  wire logic [CNT_W-1:0]    group_ratio,
    input  wire logic [PERIOD_W-1:0] align_period,
    input  wire logic                out_ready,
    output oba_stat_t                stat,
    output out_bar_t                 out_bar,
    output logic                     out_valid
);

    bar_t                in_reg;
    logic [MUL_W-1:0]    prod_reg;
    logic [Q60_W-1:0]    q60_reg;
    logic [MIN_W-1:0]    minute_reg;
    logic [MIN_W-1:0]    rem_reg;
    logic [CNT_W-1:0]    fill_reg;
    logic [TS_W-1:0]     first_time_reg;
    logic [PRICE_W-1:0]  first_open_reg;
    logic [PRICE_W-1:0]  high_reg;
    logic [PRICE_W-1:0]  low_reg;
    logic [PRICE_W-1:0]  close_reg;
    logic [VOL_W-1:0]    volume_reg;
    out_bar_t            out_reg;
    logic                out_valid_reg;

    logic [31:0]         mul_a;
    logic [MUL_W-1:0]    prod_next;
    logic [MIN_W-1:0]    minute_next;
    logic [MIN_W:0]      trial;
    logic [MIN_W:0]      trial_sub;
    logic [MIN_W-1:0]    rem_next;
    logic [CNT_W-1:0]    eff_ratio;
    logic [CNT_W-1:0]    fill_inc;

    // one shared multiplier: first ts / 60, then (ts / 60) / 60
    assign mul_a     = cmd.mul_q60 ? {5'd0, prod_reg[MUL_W-1:DIV_SHIFT]} : in_reg.ts;
    assign prod_next = MUL_W'(mul_a) * MUL_W'(DIV60_MAGIC);

    // minute = q60 - 60*q2 = q60 + 4*q2 (mod 64), and the true value is below 60
    assign minute_next = q60_reg[MIN_W-1:0] + {prod_reg[DIV_SHIFT+3:DIV_SHIFT], 2'b00};

    // restoring remainder, one bit of the minute per step
    assign trial     = {rem_reg, minute_reg[MIN_W-1]};
    assign trial_sub = trial - {1'b0, align_period};
    assign rem_next  = (trial >= {1'b0, align_period}) ? trial_sub[MIN_W-1:0]
                                                       : trial[MIN_W-1:0];

    always_comb
    begin
        if (group_ratio == '0)
            eff_ratio = CNT_W'(1);
        else if (group_ratio > MAX_RATIO)
            eff_ratio = MAX_RATIO;
        else
            eff_ratio = group_ratio;
    end

    assign fill_inc = fill_reg + CNT_W'(1);

    assign stat.rem_zero   = (rem_reg == '0);
    assign stat.group_full = (fill_inc >= eff_ratio);
    assign stat.out_free   = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            in_reg <= bar_in;
        if (cmd.mul_ts || cmd.mul_q60)
            prod_reg <= prod_next;
        if (cmd.mul_q60)
            q60_reg <= prod_reg[MUL_W-1:DIV_SHIFT];
        if (cmd.minute_load)
        begin
            minute_reg <= minute_next;
            rem_reg    <= '0;
        end
        else if (cmd.mod_step)
        begin
            minute_reg <= {minute_reg[MIN_W-2:0], 1'b0};
            rem_reg    <= rem_next;
        end
        if (cmd.accumulate)
        begin
            close_reg <= in_reg.close;
            if (fill_reg == '0)
            begin
                first_time_reg <= in_reg.ts;
                first_open_reg <= in_reg.open;
                high_reg       <= in_reg.high;
                low_reg        <= in_reg.low;
                volume_reg     <= VOL_W'(in_reg.volume);
            end
            else
            begin
                if (in_reg.high > high_reg)
                    high_reg <= in_reg.high;
                if (in_reg.low < low_reg)
                    low_reg <= in_reg.low;
                volume_reg <= volume_reg + VOL_W'(in_reg.volume);
            end
        end
        if (cmd.load_out)
        begin
            out_reg.ts     <= first_time_reg;
            out_reg.open   <= first_open_reg;
            out_reg.high   <= high_reg;
            out_reg.low    <= low_reg;
            out_reg.close  <= close_reg;
            out_reg.volume <= volume_reg;
            out_reg.count  <= fill_reg;
            out_reg.last   <= cmd.out_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_out || cmd.clear_group)
                fill_reg <= '0;
            else if (cmd.accumulate)
                fill_reg <= fill_inc;

            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_bar   = out_reg;
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ===== hdl/oba_ctrl.sv =====
// Controller: series phase, skip counter and per-item sequencing.
`default_nettype none

module oba_ctrl
    import oba_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic                in_last,
    output logic                     in_ready,
    input  wire logic [SKIP_W-1:0]   skip_count,
    input  wire logic                skip_wr,
    input  wire logic [SKIP_W-1:0]   skip_wdata,
    input  wire logic [PERIOD_W-1:0] align_period,
    input  wire oba_stat_t           stat,
    output oba_cmd_t                 cmd
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_MUL1   = 8'b0000_0010,
        S_MUL2   = 8'b0000_0100,
        S_MINUTE = 8'b0000_1000,
        S_MOD    = 8'b0001_0000,
        S_MATCH  = 8'b0010_0000,
        S_ACCUM  = 8'b0100_0000,
        S_EMIT   = 8'b1000_0000
    } state_t;

    typedef enum logic [2:0] {
        PH_SKIP  = 3'b001,
        PH_ALIGN = 3'b010,
        PH_GROUP = 3'b100
    } phase_t;

    localparam int STEP_W = $clog2(MIN_W);

    state_t              state_reg, state_next;
    phase_t              phase_reg, phase_next;
    logic [SKIP_W-1:0]   skip_left_reg, skip_left_next;
    logic                last_reg, last_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        skip_left_next = skip_left_reg;
        last_next      = last_reg;
        step_next      = step_reg;
        cmd            = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.capture = 1'b1;
                    last_next   = in_last;
                    if (phase_reg == PH_SKIP && skip_left_reg != '0)
                    begin
                        skip_left_next = skip_left_reg - SKIP_W'(1);
                        if (in_last)
                        begin
                            skip_left_next  = skip_count;
                            cmd.clear_group = 1'b1;
                        end
                    end
                    else if (phase_reg == PH_GROUP || align_period == '0)
                    begin
                        phase_next = PH_GROUP;
                        state_next = S_ACCUM;
                    end
                    else
                    begin
                        phase_next = PH_ALIGN;
                        state_next = S_MUL1;
                    end
                end
                else if (skip_wr && phase_reg == PH_SKIP)
                    skip_left_next = skip_wdata;
            end
            S_MUL1:
            begin
                cmd.mul_ts = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul_q60 = 1'b1;
                state_next  = S_MINUTE;
            end
            S_MINUTE:
            begin
                cmd.minute_load = 1'b1;
                step_next       = '0;
                state_next      = S_MOD;
            end
            S_MOD:
            begin
                cmd.mod_step = 1'b1;
                step_next    = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(MIN_W - 1))
                    state_next = S_MATCH;
            end
            S_MATCH:
            begin
                if (stat.rem_zero)
                begin
                    phase_next = PH_GROUP;
                    state_next = S_ACCUM;
                end
                else
                begin
                    // not aligned: item dropped, series may still end here
                    if (last_reg)
                    begin
                        phase_next      = PH_SKIP;
                        skip_left_next  = skip_count;
                        cmd.clear_group = 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            S_ACCUM:
            begin
                cmd.accumulate = 1'b1;
                if (stat.group_full || last_reg)
                    state_next = S_EMIT;
                else
                    state_next = S_IDLE;
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    cmd.out_last = last_reg;
                    if (last_reg)
                    begin
                        phase_next     = PH_SKIP;
                        skip_left_next = skip_count;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_SKIP;
            skip_left_reg <= '0;
            last_reg      <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            skip_left_reg <= skip_left_next;
            last_reg      <= last_next;
            step_reg      <= step_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/ohlc_bar_aggregator.sv =====
// Top level of the OHLC bar aggregator: configuration registers, controller and datapath.
//
//  Channel  Signals                            Item
//  s_*      s_tvalid s_tready s_tdata s_tlast  input bar, tlast = end of series
//  m_*      m_tvalid m_tready m_tdata m_tlast  merged bar, tlast = last of series
//  cfg_*    cfg_valid cfg_ready cfg_index      register write (0 ratio, 1 skip,
//           cfg_data                           2 align period), always ready
//
// A skipped bar passes S_IDLE only; a grouped bar S_IDLE and S_ACCUM, plus S_EMIT when it
// closes a group. A bar in the alignment search first takes two passes through the shared
// 32x32 multiplier for the minute, then a 6-step remainder by the period.
// Reset leaves ratio 1, skip 0, period 0 and an empty group; no clearing pass.
// A full output register stalls the controller only when a group has to be emitted.
`default_nettype none

module ohlc_bar_aggregator
    import oba_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // [31:0] in_timestamp, [63:32] in_open, [95:64] in_high, [127:96] in_low,
    // [159:128] in_close, [191:160] in_volume
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    input  wire logic                  s_tlast,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [31:0] out_timestamp, [63:32] out_open, [95:64] out_high, [127:96] out_low,
    // [159:128] out_close, [201:160] out_volume, [212:202] merged_count, [215:213] zero
    output logic [OUT_DATA_W-1:0]      m_tdata,
    output logic                       m_tlast,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic [CNT_W-1:0]    ratio_reg;
    logic [SKIP_W-1:0]   skip_reg;
    logic [PERIOD_W-1:0] period_reg;
    logic                cfg_wr;
    logic                skip_wr;
    bar_t                bar_in;
    out_bar_t            out_bar;
    oba_cmd_t            cmd;
    oba_stat_t           stat;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign skip_wr   = cfg_wr && (cfg_index == REG_SKIP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ratio_reg  <= CNT_W'(1);
            skip_reg   <= '0;
            period_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                REG_RATIO:  ratio_reg  <= cfg_data[CNT_W-1:0];
                REG_SKIP:   skip_reg   <= cfg_data[SKIP_W-1:0];
                REG_PERIOD: period_reg <= cfg_data[PERIOD_W-1:0];
                default:    ;
            endcase
        end
    end

    assign bar_in.ts     = s_tdata[31:0];
    assign bar_in.open   = s_tdata[63:32];
    assign bar_in.high   = s_tdata[95:64];
    assign bar_in.low    = s_tdata[127:96];
    assign bar_in.close  = s_tdata[159:128];
    assign bar_in.volume = s_tdata[191:160];

    oba_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_last      (s_tlast),
        .in_ready     (s_tready),
        .skip_count   (skip_reg),
        .skip_wr      (skip_wr),
        .skip_wdata   (cfg_data[SKIP_W-1:0]),
        .align_period (period_reg),
        .stat         (stat),
        .cmd          (cmd)
    );

    oba_datapath u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .bar_in       (bar_in),
        .cmd          (cmd),
        .group_ratio  (ratio_reg),
        .align_period (period_reg),
        .out_ready    (m_tready),
        .stat         (stat),
        .out_bar      (out_bar),
        .out_valid    (m_tvalid)
    );

    assign m_tdata = {3'b000, out_bar.count, out_bar.volume, out_bar.close,
                      out_bar.low, out_bar.high, out_bar.open, out_bar.ts};
    assign m_tlast = out_bar.last;

    // a merged bar always holds between one bar and the largest ratio
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[212:202] != '0) && (m_tdata[212:202] <= MAX_RATIO))
    else $error("merged count out of range");

    // results are produced only while an item is being worked on
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result appeared with the input side idle");

    // configuration port never back-pressures
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

`default_nettype wire
